[src/dfr_pkg.sv]
// shared types and constants for the datagram frame reassembly core
// no dependencies

package dfr_pkg;

	localparam int SLOT_TOTAL   = 8;
	localparam int SLOT_W       = $clog2(SLOT_TOTAL);
	localparam int MAX_PACKETS  = 1024;
	localparam int SLOT_BYTES   = 1048576;
	localparam int HEADER_BYTES = 16;
	localparam int CHUNK_LIMIT  = 65000;
	localparam int MAX_DATAGRAM = 1500;
	localparam int CHUNK_W      = 16;
	localparam int WORD_BITS    = 64;

	localparam int STAT_W = 3;
	localparam logic [STAT_W-1:0] ST_STORED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_HDR   = 3'd2;
	localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic clear;
		logic capture;
		logic eval;
		logic take;
		logic wipe;
		logic look;
		logic bits;
		logic load;
	} dfr_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic wipe_last;
		logic bad;
		logic take;
		logic reject;
		logic out_full;
	} dfr_stat_t;

endpackage

[src/dfr_ctrl.sv]
// controller state machine for the reassembly core
// depends on dfr_pkg

module dfr_ctrl import dfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dfr_stat_t stat,
	output dfr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_EVAL, S_TAKE, S_WIPE, S_LOOK, S_BITS, S_FIN
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE:  cmd.capture = in_valid;
			S_EVAL:  cmd.eval = 1'b1;
			S_TAKE:  cmd.take = 1'b1;
			S_WIPE:  cmd.wipe = 1'b1;
			S_LOOK:  cmd.look = 1'b1;
			S_BITS:  cmd.bits = 1'b1;
			S_FIN:   cmd.load = !stat.out_full;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (stat.clear_last) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_EVAL;
				S_EVAL: begin
					if (stat.bad) state_q <= S_FIN;
					else if (stat.take) state_q <= S_TAKE;
					else state_q <= S_LOOK;
				end
				S_TAKE:  state_q <= S_WIPE;
				S_WIPE:  if (stat.wipe_last) state_q <= S_LOOK;
				S_LOOK:  state_q <= stat.reject ? S_FIN : S_BITS;
				S_BITS:  state_q <= S_FIN;
				S_FIN:   if (!stat.out_full) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

endmodule

[src/dfr_datapath.sv]
// datapath: request registers, slot table, received bitmap memory, result register
// depends on dfr_pkg

module dfr_datapath import dfr_pkg::*; #(
	parameter int MAX_PKTS = MAX_PACKETS,
	parameter int SLOT_SZ  = SLOT_BYTES,
	parameter int HDR      = HEADER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dfr_cmd_t          cmd,
	output dfr_stat_t         stat,
	input  logic [10:0]       datagram_len,
	input  logic [31:0]       frame_seq,
	input  logic [31:0]       packet_count,
	input  logic [31:0]       packet_pos,
	input  logic [31:0]       chunk_size,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic              write_enable,
	output logic [2:0]        slot_index,
	output logic [19:0]       write_offset,
	output logic [10:0]       payload_bytes,
	output logic              frame_complete,
	output logic [20:0]       frame_size,
	output logic              evicted_incomplete
);

	localparam int CNT_W  = $clog2(MAX_PKTS + 1);
	localparam int OFF_W  = CNT_W + CHUNK_W;
	localparam int BYTE_W = $clog2(SLOT_SZ + 1);
	localparam int EW     = (OFF_W + 1 > BYTE_W) ? OFF_W + 1 : BYTE_W;
	localparam int WORDS  = (MAX_PKTS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH  = SLOT_TOTAL * WORDS;
	localparam int AW     = $clog2(DEPTH);
	localparam logic [AW-1:0] WORDS_A = AW'(WORDS);

	logic [10:0]  len_q;
	logic [31:0]  seq_q, cnt_q, idx_q, chunk_q;
	logic [SLOT_W-1:0] slot;

	logic [31:0]       seq_a_q  [SLOT_TOTAL];
	logic [CNT_W-1:0]  rcv_a_q  [SLOT_TOTAL];
	logic [CNT_W-1:0]  exp_a_q  [SLOT_TOTAL];
	logic [BYTE_W-1:0] res_a_q  [SLOT_TOTAL];
	logic [BYTE_W-1:0] fill_a_q [SLOT_TOTAL];
	logic              done_a_q [SLOT_TOTAL];

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q, mem_wd;
	logic [AW-1:0]        ptr_q, base, word_a, mem_wa;
	logic                 mem_we;

	logic [OFF_W-1:0]  off_q, want_q;
	logic [EW-1:0]     end_w, end_q;
	logic [BYTE_W-1:0] want_cap;
	logic [10:0]       pay_w;

	logic [STAT_W-1:0] code_q;
	logic              we_q, comp_q, evict_q;
	logic [BYTE_W-1:0] fsize_q;

	logic              bad_w, take_w, mism_w, ovf_w, hit_w;
	logic [CNT_W-1:0]  rcv_next;
	logic [BYTE_W-1:0] fill_next;
	logic              comp_w;

	assign slot   = seq_q[SLOT_W-1:0];
	assign pay_w  = 11'(len_q - 11'(HDR));
	assign base   = AW'(slot) * WORDS_A;
	assign word_a = base + AW'(idx_q >> 6);

	assign bad_w = (len_q < 11'(HDR)) || (len_q > 11'(MAX_DATAGRAM)) ||
		(cnt_q == 32'd0) || (cnt_q > 32'(MAX_PKTS)) || (idx_q >= cnt_q) ||
		(chunk_q == 32'd0) || (chunk_q > 32'(CHUNK_LIMIT));
	assign take_w = (exp_a_q[slot] == '0) || (seq_a_q[slot] != seq_q);

	assign want_cap = (EW'(want_q) > EW'(SLOT_SZ)) ? BYTE_W'(SLOT_SZ) : BYTE_W'(want_q);

	assign end_w  = EW'(off_q) + EW'(pay_w);
	assign mism_w = exp_a_q[slot] != cnt_q[CNT_W-1:0];
	assign ovf_w  = end_w > EW'(res_a_q[slot]);

	assign hit_w     = rd_q[idx_q[5:0]];
	assign rcv_next  = rcv_a_q[slot] + CNT_W'(!hit_w);
	assign fill_next = (!hit_w && (end_q > EW'(fill_a_q[slot]))) ?
		BYTE_W'(end_q) : fill_a_q[slot];
	assign comp_w    = (rcv_next == exp_a_q[slot]) && !done_a_q[slot];

	assign stat.clear_last = (ptr_q == AW'(DEPTH - 1));
	assign stat.wipe_last  = (ptr_q == AW'(WORDS - 1));
	assign stat.bad        = bad_w;
	assign stat.take       = take_w;
	assign stat.reject     = mism_w || ovf_w;
	assign stat.out_full   = out_valid && out_stall;

	always_comb begin
		mem_we = cmd.clear || cmd.wipe || (cmd.bits && !hit_w);
		mem_wa = word_a;
		mem_wd = rd_q | (WORD_BITS'(1) << idx_q[5:0]);
		if (cmd.clear) begin
			mem_wa = ptr_q;
			mem_wd = '0;
		end else if (cmd.wipe) begin
			mem_wa = base + ptr_q;
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[word_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			len_q   <= datagram_len;
			seq_q   <= frame_seq;
			cnt_q   <= packet_count;
			idx_q   <= packet_pos;
			chunk_q <= chunk_size;
		end
		if (cmd.eval) begin
			off_q  <= idx_q[CNT_W-1:0] * chunk_q[CHUNK_W-1:0];
			want_q <= cnt_q[CNT_W-1:0] * chunk_q[CHUNK_W-1:0];
		end
		if (cmd.look) end_q <= end_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			code_q    <= ST_STORED;
			we_q      <= 1'b0;
			comp_q    <= 1'b0;
			evict_q   <= 1'b0;
			fsize_q   <= '0;
			out_valid <= 1'b0;
			status    <= ST_STORED;
			write_enable       <= 1'b0;
			slot_index         <= '0;
			write_offset       <= '0;
			payload_bytes      <= '0;
			frame_complete     <= 1'b0;
			frame_size         <= '0;
			evicted_incomplete <= 1'b0;
			for (int i = 0; i < SLOT_TOTAL; i++) begin
				seq_a_q[i]  <= '1;
				rcv_a_q[i]  <= '0;
				exp_a_q[i]  <= '0;
				res_a_q[i]  <= '0;
				fill_a_q[i] <= '0;
				done_a_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.clear) ptr_q <= ptr_q + AW'(1);
			if (cmd.capture) begin
				we_q    <= 1'b0;
				comp_q  <= 1'b0;
				evict_q <= 1'b0;
				fsize_q <= '0;
				ptr_q   <= '0;
			end
			if (cmd.eval && bad_w) code_q <= ST_BAD_HDR;
			if (cmd.take) begin
				evict_q         <= !done_a_q[slot] && (rcv_a_q[slot] != '0);
				seq_a_q[slot]   <= seq_q;
				rcv_a_q[slot]   <= '0;
				exp_a_q[slot]   <= cnt_q[CNT_W-1:0];
				done_a_q[slot]  <= 1'b0;
				fill_a_q[slot]  <= '0;
				if (res_a_q[slot] < want_cap) res_a_q[slot] <= want_cap;
			end
			if (cmd.wipe) ptr_q <= ptr_q + AW'(1);
			if (cmd.look) begin
				if (mism_w) code_q <= ST_MISMATCH;
				else if (ovf_w) code_q <= ST_OVERFLOW;
			end
			if (cmd.bits) begin
				code_q          <= hit_w ? ST_DUPLICATE : ST_STORED;
				we_q            <= !hit_w;
				rcv_a_q[slot]   <= rcv_next;
				fill_a_q[slot]  <= fill_next;
				comp_q          <= comp_w;
				fsize_q         <= fill_next;
				if (comp_w) done_a_q[slot] <= 1'b1;
			end
			if (cmd.load) begin
				out_valid          <= 1'b1;
				status             <= code_q;
				write_enable       <= we_q;
				slot_index         <= 3'(slot);
				write_offset       <= we_q ? off_q[19:0] : 20'd0;
				payload_bytes      <= (code_q == ST_BAD_HDR) ? 11'd0 : pay_w;
				frame_complete     <= comp_q;
				frame_size         <= comp_q ? 21'(fsize_q) : 21'd0;
				evicted_incomplete <= evict_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

[src/datagram_frame_reassembly_core.sv]
// top level of the datagram frame reassembly core: controller plus datapath
// depends on dfr_pkg, dfr_ctrl, dfr_datapath
//
// channel   direction  handshake             payload
// request   in         in_valid / in_stall   datagram_len frame_seq packet_count
//                                            packet_pos chunk_size
// result    out        out_valid / out_stall status write_enable slot_index
//                                            write_offset payload_bytes frame_complete
//                                            frame_size evicted_incomplete
//
// one request at a time; a bad header goes from EVAL to FIN, a reject passes LOOK, a
// normal request LOOK and BITS on the way to the result register, plus TAKE and a wipe
// of WORDS (MAX_PACKETS/64 rounded up) bitmap words when a new sequence takes a slot
// after reset the bitmap memory is cleared, SLOT_TOTAL*WORDS words (128 by default),
// with in_stall high
// a new request is taken while a result waits; it holds at its last step until
// the result register is free

module datagram_frame_reassembly_core import dfr_pkg::*; #(
	parameter int MAX_PKTS = MAX_PACKETS,
	parameter int SLOT_SZ  = SLOT_BYTES,
	parameter int HDR      = HEADER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [10:0]       datagram_len,
	input  logic [31:0]       frame_seq,
	input  logic [31:0]       packet_count,
	input  logic [31:0]       packet_pos,
	input  logic [31:0]       chunk_size,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic              write_enable,
	output logic [2:0]        slot_index,
	output logic [19:0]       write_offset,
	output logic [10:0]       payload_bytes,
	output logic              frame_complete,
	output logic [20:0]       frame_size,
	output logic              evicted_incomplete
);

	dfr_cmd_t  cmd;
	dfr_stat_t stat;

	dfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dfr_datapath #(
		.MAX_PKTS (MAX_PKTS),
		.SLOT_SZ  (SLOT_SZ),
		.HDR      (HDR)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.datagram_len       (datagram_len),
		.frame_seq          (frame_seq),
		.packet_count       (packet_count),
		.packet_pos         (packet_pos),
		.chunk_size         (chunk_size),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.write_enable       (write_enable),
		.slot_index         (slot_index),
		.write_offset       (write_offset),
		.payload_bytes      (payload_bytes),
		.frame_complete     (frame_complete),
		.frame_size         (frame_size),
		.evicted_incomplete (evicted_incomplete)
	);

	a_we_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> status == ST_STORED)
		else $error("write without stored status");

	a_complete_we: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_complete |-> write_enable)
		else $error("completion without a new packet");

	a_evict_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_incomplete |-> status != ST_BAD_HDR)
		else $error("eviction on a bad header");

endmodule

[dv/datagram_frame_reassembly_core_tb.sv]
// self-checking testbench for datagram_frame_reassembly_core
// predicts slot and bitmap bookkeeping per request and compares every result
// depends on dfr_pkg and the core rtl
`timescale 1ns / 100ps

module datagram_frame_reassembly_core_tb;
	import dfr_pkg::*;

	typedef struct packed {
		logic [10:0] len;
		logic [31:0] seq;
		logic [31:0] cnt;
		logic [31:0] idx;
		logic [31:0] chunk;
	} req_t;

	typedef struct packed {
		logic [2:0]  st;
		logic        we;
		logic [2:0]  slot;
		logic [19:0] woff;
		logic [10:0] pay;
		logic        done;
		logic [20:0] fsize;
		logic        evict;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [10:0] datagram_len = 0;
	logic [31:0] frame_seq = 0, packet_count = 0, packet_pos = 0, chunk_size = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic write_enable;
	logic [2:0] slot_index;
	logic [19:0] write_offset;
	logic [10:0] payload_bytes;
	logic frame_complete;
	logic [20:0] frame_size;
	logic evicted_incomplete;

	datagram_frame_reassembly_core u_top (.*);

	// predictor state
	logic [31:0] p_seq [SLOT_TOTAL];
	int unsigned p_rcv [SLOT_TOTAL];
	int unsigned p_exp [SLOT_TOTAL];
	longint unsigned p_res [SLOT_TOTAL];
	longint unsigned p_fill [SLOT_TOTAL];
	bit p_done [SLOT_TOTAL];
	bit p_bits [SLOT_TOTAL][MAX_PACKETS];

	req_t pending_reqs[$];
	res_t expected_results[$];
	int errors = 0, n_results = 0, n_complete = 0, n_evict = 0;
	int send_idle = 0, recv_stall = 0;
	int hold_off = 0;
	bit hold_req = 0, hold_done = 0;
	bit pause_send = 0;
	longint cycles = 0;

	initial forever #10 clk = ~clk;

	function automatic res_t reassemble(req_t r);
		res_t o;
		int unsigned s;
		longint unsigned want, off, fin;
		o = '0;
		s = r.seq % SLOT_TOTAL;
		o.slot = 3'(s);
		if (r.len < HEADER_BYTES || r.len > MAX_DATAGRAM || r.cnt == 0
				|| r.cnt > MAX_PACKETS || r.idx >= r.cnt || r.chunk == 0
				|| r.chunk > CHUNK_LIMIT) begin
			o.st = ST_BAD_HDR;
			return o;
		end
		o.pay = 11'(r.len - HEADER_BYTES);
		if (p_exp[s] == 0 || p_seq[s] != r.seq) begin
			want = longint'(r.chunk) * longint'(r.cnt);
			if (want > SLOT_BYTES)
				want = SLOT_BYTES;
			if (!p_done[s] && p_rcv[s] > 0)
				o.evict = 1;
			p_seq[s] = r.seq;
			p_rcv[s] = 0;
			p_exp[s] = r.cnt;
			p_done[s] = 0;
			p_fill[s] = 0;
			if (p_res[s] < want)
				p_res[s] = want;
			for (int i = 0; i < MAX_PACKETS; i++)
				p_bits[s][i] = 0;
		end
		if (p_exp[s] != r.cnt) begin
			o.st = ST_MISMATCH;
			return o;
		end
		off = longint'(r.idx) * longint'(r.chunk);
		fin = off + o.pay;
		if (fin > p_res[s]) begin
			o.st = ST_OVERFLOW;
			return o;
		end
		if (p_bits[s][r.idx]) begin
			o.st = ST_DUPLICATE;
		end else begin
			p_bits[s][r.idx] = 1;
			p_rcv[s]++;
			if (fin > p_fill[s])
				p_fill[s] = fin;
			o.st = ST_STORED;
			o.we = 1;
			o.woff = 20'(off);
		end
		if (p_rcv[s] == p_exp[s] && !p_done[s]) begin
			p_done[s] = 1;
			o.done = 1;
			o.fsize = 21'(p_fill[s]);
		end
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		req_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(reassemble({datagram_len, frame_seq,
					packet_count, packet_pos, chunk_size}));
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && !pause_send
						&& $urandom_range(99) >= send_idle) begin
					r = pending_reqs.pop_front();
					in_valid <= 1;
					datagram_len <= r.len;
					frame_seq <= r.seq;
					packet_count <= r.cnt;
					packet_pos <= r.idx;
					chunk_size <= r.chunk;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_off <= 300;
			out_stall <= 1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t a, e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			a = {status, write_enable, slot_index, write_offset, payload_bytes,
				frame_complete, frame_size, evicted_incomplete};
			n_results++;
			if (a.done) n_complete++;
			if (a.evict) n_evict++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, a);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (a !== e) begin
					errors++;
					$display("%0t: mismatch exp st=%0d we=%0d slot=%0d off=%0d pay=%0d",
						$time, e.st, e.we, e.slot, e.woff, e.pay);
					$display("    exp done=%0d size=%0d evict=%0d", e.done, e.fsize, e.evict);
					$display("    act st=%0d we=%0d slot=%0d off=%0d pay=%0d",
						a.st, a.we, a.slot, a.woff, a.pay);
					$display("    act done=%0d size=%0d evict=%0d", a.done, a.fsize, a.evict);
				end
			end
		end
	end

	function automatic void add(int l, int unsigned s, int unsigned c, int unsigned i,
			int unsigned k);
		req_t r;
		r.len = 11'(l);
		r.seq = s;
		r.cnt = c;
		r.idx = i;
		r.chunk = k;
		pending_reqs.push_back(r);
	endfunction

	// one frame, packets shuffled, some dups and drops
	function automatic void add_frame(int unsigned s);
		int unsigned c, k, n;
		int unsigned order[$];
		c = ($urandom_range(9) == 0) ? $urandom_range(MAX_PACKETS) + 0 : $urandom_range(1, 12);
		if (c == 0) c = 1;
		k = ($urandom_range(3) == 0) ? $urandom_range(1, CHUNK_LIMIT) : $urandom_range(1, 1600);
		for (int i = 0; i < c && i < 14; i++)
			order.push_back(c <= 14 ? i : $urandom_range(c - 1));
		order.shuffle();
		if ($urandom_range(4) == 0 && order.size() > 1) void'(order.pop_back());
		foreach (order[i]) begin
			n = $urandom_range(15);
			if (n == 0)
				add($urandom_range(2047), $urandom, $urandom, $urandom, $urandom);
			else if (n == 1)
				add($urandom_range(16, 1500), s, c + 1, order[i], k);
			else
				add($urandom_range(16, 1500), s, c, order[i], k);
			if ($urandom_range(7) == 0)
				add($urandom_range(16, 1500), s, c, order[i], k);
		end
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(int si, int rs, int n);
		send_idle = si;
		recv_stall = rs;
		while (n > 0) begin
			add_frame($urandom_range(3) == 0 ? $urandom : $urandom_range(40));
			n -= 8;
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < SLOT_TOTAL; i++) begin
			p_seq[i] = '1;
			p_rcv[i] = 0;
			p_exp[i] = 0;
			p_res[i] = 0;
			p_fill[i] = 0;
			p_done[i] = 0;
			for (int j = 0; j < MAX_PACKETS; j++)
				p_bits[i][j] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed
		add(0, 1, 1, 0, 100);
		add(15, 1, 1, 0, 100);
		add(1501, 1, 1, 0, 100);
		add(2047, 1, 1, 0, 100);
		add(100, 1, 0, 0, 100);
		add(100, 1, 1025, 0, 100);
		add(100, 1, 4, 4, 100);
		add(100, 1, 4, 0, 0);
		add(100, 1, 4, 0, 65001);
		add(100, 32'hffffffff, 2, 0, 200);
		add(16, 32'hffffffff, 2, 0, 200);
		add(100, 32'hffffffff, 3, 1, 200);
		add(1500, 32'hffffffff, 2, 1, 200);
		add(100, 32'hffffffff, 2, 1, 200);
		add(116, 32'h7, 2, 1, 100);
		add(100, 32'hffffffff, 2, 1, 200);
		add(1500, 5, 1024, 1023, 65000);
		add(1500, 5, 1024, 1023, 65000);
		add(1500, 13, 1, 0, 65000);
		add(100, 2, 3, 0, 1);
		add(100, 10, 1024, 0, 1024);
		add(1500, 3, 1024, 1023, 1024);
		add(1500, 3, 1024, 0, 1);
		add(1500, 32'h80000000, 1, 0, 1);
		drain();
		run_phase(0, 0, 330);
		run_phase(52, 0, 330);
		run_phase(0, 52, 330);
		run_phase(33, 33, 330);
		// long receiver hold-off with the sender busy
		send_idle = 0;
		recv_stall = 0;
		hold_req = 1;
		for (int i = 0; i < 6; i++)
			add_frame(i);
		// sender pause until everything has come back
		pause_send = 1;
		while (expected_results.size() > 0 || in_valid) @(posedge clk);
		pause_send = 0;
		drain();
		$display("%0d results checked, %0d frames completed, %0d incomplete evictions",
			n_results, n_complete, n_evict);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
